FILE: rtl/alu8_pkg.sv
// shared types, opcodes and the booth step function for the alu8 block
// no dependencies; used by every module of the block

package alu8_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int BOOTH_STEPS = 8;
   localparam int BOOTH_HALF  = BOOTH_STEPS / 2;

   localparam logic [7:0] FUNC_ADD = 8'h01;
   localparam logic [7:0] FUNC_SUB = 8'h02;
   localparam logic [7:0] FUNC_MUL = 8'h03;
   localparam logic [7:0] FUNC_AND = 8'h04;
   localparam logic [7:0] FUNC_OR  = 8'h05;
   localparam logic [7:0] FUNC_NOT = 8'h06;
   localparam logic [7:0] FUNC_XOR = 8'h07;
   localparam logic [7:0] FUNC_SHR = 8'h08;
   localparam logic [7:0] FUNC_SHL = 8'h09;

   typedef enum logic [3:0] {
      KIND_ADD,
      KIND_SUB,
      KIND_MUL,
      KIND_AND,
      KIND_OR,
      KIND_NOT,
      KIND_XOR,
      KIND_SHR,
      KIND_SHL,
      KIND_BAD
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  op_a;
      logic [7:0]  op_b;
   } cmd_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] q;
      logic       qprev;
   } booth_type;

   typedef struct packed {
      logic [15:0] result;
      logic        carry_flag;
      logic        zero_flag;
      logic        overflow_flag;
      logic        sign_flag;
      logic        invalid_op;
   } rsp_type;

   // one radix-2 booth step: add or subtract, then arithmetic shift of acc:q
   function automatic booth_type booth_step(booth_type s, logic [7:0] m);
      booth_type  r;
      logic [7:0] sum;
      unique case ({s.q[0], s.qprev})
         2'b10: begin
            sum = s.acc - m;
         end
         2'b01: begin
            sum = s.acc + m;
         end
         default: begin
            sum = s.acc;
         end
      endcase
      r.acc   = {sum[7], sum[7:1]};
      r.q     = {sum[0], s.q[7:1]};
      r.qprev = s.q[0];
      return r;
   endfunction

endpackage

FILE: rtl/alu8_front.sv
// front end: accepts request transactions and decodes the opcode
// depends on alu8_pkg

module alu8_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           op_a,
   input  logic [7:0]           op_b,
   input  logic [7:0]           func,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output alu8_pkg::cmd_type    cmd
);

   logic                 valid_ff;
   logic                 valid_in;
   alu8_pkg::cmd_type    cmd_ff;
   alu8_pkg::cmd_type    cmd_in;
   alu8_pkg::op_kind_type kind;

   always_comb begin
      unique case (func)
         alu8_pkg::FUNC_ADD: kind = alu8_pkg::KIND_ADD;
         alu8_pkg::FUNC_SUB: kind = alu8_pkg::KIND_SUB;
         alu8_pkg::FUNC_MUL: kind = alu8_pkg::KIND_MUL;
         alu8_pkg::FUNC_AND: kind = alu8_pkg::KIND_AND;
         alu8_pkg::FUNC_OR:  kind = alu8_pkg::KIND_OR;
         alu8_pkg::FUNC_NOT: kind = alu8_pkg::KIND_NOT;
         alu8_pkg::FUNC_XOR: kind = alu8_pkg::KIND_XOR;
         alu8_pkg::FUNC_SHR: kind = alu8_pkg::KIND_SHR;
         alu8_pkg::FUNC_SHL: kind = alu8_pkg::KIND_SHL;
         default:            kind = alu8_pkg::KIND_BAD;
      endcase
   end

   assign in_ready  = !valid_ff || cmd_ready;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      valid_in = valid_ff;
      cmd_in   = cmd_ff;
      if (in_ready) begin
         valid_in    = in_valid;
         cmd_in.kind = kind;
         cmd_in.op_a = op_a;
         cmd_in.op_b = op_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cmd_ff <= cmd_in;
   end

endmodule

FILE: rtl/alu8_queue.sv
// short fifo between the decode front end and the execute back end
// depends on alu8_pkg

module alu8_queue #(
   parameter int DEPTH = alu8_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  alu8_pkg::cmd_type wr_cmd,
   output logic              rd_valid,
   input  logic              rd_ready,
   output alu8_pkg::cmd_type rd_cmd
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   alu8_pkg::cmd_type mem [DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign wr_ready = (count_ff != CNT_FULL);
   assign rd_valid = (count_ff != '0);
   assign rd_cmd   = mem[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wr_cmd;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_FULL)
      else $error("queue count above depth");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count missed a push");

   assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("queue count missed a pop");

endmodule

FILE: rtl/alu8_back.sv
// back end: executes commands in two stages, booth multiply split over both
// depends on alu8_pkg

module alu8_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  alu8_pkg::cmd_type cmd,
   output logic              out_valid,
   input  logic              out_ready,
   output alu8_pkg::rsp_type out_rsp
);

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   alu8_pkg::op_kind_type s1_kind_ff;
   logic [7:0]            s1_mcand_ff;
   alu8_pkg::booth_type   s1_booth_ff;
   alu8_pkg::booth_type   s1_booth_in;
   logic [15:0]           s1_result_ff;
   logic [15:0]           s1_result_in;

   logic                  out_valid_ff;
   logic                  out_valid_in;
   alu8_pkg::rsp_type     out_rsp_ff;
   alu8_pkg::rsp_type     out_rsp_in;

   logic                  out_load;
   logic                  s1_load;
   logic [7:0]            neg_b;
   alu8_pkg::booth_type   s2_booth;
   logic [15:0]           s2_result;

   assign out_load  = !out_valid_ff || out_ready;
   assign s1_load   = !s1_valid_ff || out_load;
   assign cmd_ready = s1_load;
   assign out_valid = out_valid_ff;
   assign out_rsp   = out_rsp_ff;

   // stage one: simple operations and the first half of the booth steps
   always_comb begin
      neg_b = ~cmd.op_b + 8'd1;
      unique case (cmd.kind)
         alu8_pkg::KIND_ADD: s1_result_in = {7'd0, {1'b0, cmd.op_a} + {1'b0, cmd.op_b}};
         alu8_pkg::KIND_SUB: s1_result_in = {7'd0, {1'b0, cmd.op_a} + {1'b0, neg_b}};
         alu8_pkg::KIND_AND: s1_result_in = {8'd0, cmd.op_a & cmd.op_b};
         alu8_pkg::KIND_OR:  s1_result_in = {8'd0, cmd.op_a | cmd.op_b};
         alu8_pkg::KIND_NOT: s1_result_in = {8'd0, ~cmd.op_a};
         alu8_pkg::KIND_XOR: s1_result_in = {8'd0, cmd.op_a ^ cmd.op_b};
         alu8_pkg::KIND_SHR: s1_result_in = {9'd0, cmd.op_a[7:1]};
         alu8_pkg::KIND_SHL: s1_result_in = {7'd0, cmd.op_a, 1'b0};
         default:            s1_result_in = 16'd0;
      endcase
      s1_booth_in.acc   = 8'd0;
      s1_booth_in.q     = cmd.op_b;
      s1_booth_in.qprev = 1'b0;
      for (int i = 0; i < alu8_pkg::BOOTH_HALF; i++) begin
         s1_booth_in = alu8_pkg::booth_step(s1_booth_in, cmd.op_a);
      end
      s1_valid_in = s1_load ? cmd_valid : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (s1_load) begin
         s1_kind_ff   <= cmd.kind;
         s1_mcand_ff  <= cmd.op_a;
         s1_booth_ff  <= s1_booth_in;
         s1_result_ff <= s1_result_in;
      end
   end

   // stage two: second half of the booth steps and the flags
   always_comb begin
      s2_booth = s1_booth_ff;
      for (int i = 0; i < alu8_pkg::BOOTH_STEPS - alu8_pkg::BOOTH_HALF; i++) begin
         s2_booth = alu8_pkg::booth_step(s2_booth, s1_mcand_ff);
      end
      s2_result = (s1_kind_ff == alu8_pkg::KIND_MUL) ? {s2_booth.acc, s2_booth.q}
                                                     : s1_result_ff;
      if (s1_kind_ff == alu8_pkg::KIND_BAD) begin
         out_rsp_in = '0;
         out_rsp_in.invalid_op = 1'b1;
      end else begin
         out_rsp_in.result        = s2_result;
         out_rsp_in.carry_flag    = |s2_result[15:8];
         out_rsp_in.zero_flag     = (s2_result == 16'd0);
         out_rsp_in.overflow_flag = |s2_result[15:7];
         out_rsp_in.sign_flag     = s2_result[7];
         out_rsp_in.invalid_op    = 1'b0;
      end
      out_valid_in = out_load ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_load) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rsp_ff.invalid_op |-> out_rsp_ff.result == 16'd0
         && !out_rsp_ff.carry_flag && !out_rsp_ff.zero_flag
         && !out_rsp_ff.overflow_flag && !out_rsp_ff.sign_flag)
      else $error("invalid opcode transaction carries data or flags");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rsp_ff.carry_flag |-> out_rsp_ff.overflow_flag)
      else $error("carry set without overflow");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_rsp_ff.zero_flag |-> out_rsp_ff.result == 16'd0
         && !out_rsp_ff.invalid_op)
      else $error("zero flag with nonzero result");

endmodule

FILE: rtl/alu8_booth_flags_top.sv
// top level of the 8-bit alu with booth multiplier and flags
// depends on alu8_pkg, alu8_front, alu8_queue, alu8_back

// The block takes one transaction per clock cycle while neither side stalls and
// returns one response per transaction, in order. A transaction passes the decode
// register, the command queue, the first execute stage and the output register.
// The eight Booth multiply steps run four in each execute stage, which keeps MUL
// at the same one-per-cycle rate as the other opcodes. The queue lets the
// request side keep going for QUEUE_DEPTH transactions while the response
// side is stalled. An unknown opcode returns zero with invalid_op set.

module alu8_booth_flags_top #(
   parameter int QUEUE_DEPTH = alu8_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // op_a, op_b
   input  logic [7:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // result, carry_flag, zero_flag, overflow_flag, sign_flag
   output logic [0:0]  rsp_tuser    // invalid_op
);

   logic              front_valid;
   logic              front_ready;
   alu8_pkg::cmd_type front_cmd;
   logic              queue_valid;
   logic              queue_ready;
   alu8_pkg::cmd_type queue_cmd;
   alu8_pkg::rsp_type rsp;

   alu8_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .op_a      (req_tdata[7:0]),
      .op_b      (req_tdata[15:8]),
      .func      (req_tuser),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   alu8_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_cmd   (front_cmd),
      .rd_valid (queue_valid),
      .rd_ready (queue_ready),
      .rd_cmd   (queue_cmd)
   );

   alu8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {4'd0, rsp.sign_flag, rsp.overflow_flag, rsp.zero_flag,
                       rsp.carry_flag, rsp.result};
   assign rsp_tuser = rsp.invalid_op;

endmodule

FILE: sim/alu8_booth_flags_tb.sv
// self-checking testbench for alu8_booth_flags_top: directed and random alu transactions
// with and without random stalls on both sides; a scoreboard class predicts each response in order
// depends on alu8_pkg and alu8_booth_flags_top
`timescale 1ns / 1ps

class alu8_result_tracker;
   alu8_pkg::rsp_type pending_results[$];
   int unsigned       errors;

   function new();
      errors = 0;
   endfunction

   function alu8_pkg::rsp_type alu_outcome(logic [7:0] a, logic [7:0] b, logic [7:0] func);
      alu8_pkg::rsp_type r;
      logic [15:0]       value;
      logic [7:0]        acc;
      logic [7:0]        q;
      logic [7:0]        neg_b;
      logic              qprev;
      logic              q0;
      logic              known;
      int                i;
      known = 1'b1;
      value = 16'h0000;
      case (func)
         alu8_pkg::FUNC_ADD: begin
            value = {8'h00, a} + {8'h00, b};
         end
         alu8_pkg::FUNC_SUB: begin
            neg_b = 8'h00 - b;
            value = {8'h00, a} + {8'h00, neg_b};
         end
         alu8_pkg::FUNC_MUL: begin
            // radix-2 booth, accumulator wraps at 8 bits before each shift
            acc   = 8'h00;
            q     = b;
            qprev = 1'b0;
            for (i = 0; i < 8; i++) begin
               q0 = q[0];
               if (q0 && !qprev) acc = acc - a;
               else if (!q0 && qprev) acc = acc + a;
               q     = {acc[0], q[7:1]};
               acc   = {acc[7], acc[7:1]};
               qprev = q0;
            end
            value = {acc, q};
         end
         alu8_pkg::FUNC_AND: value = {8'h00, a & b};
         alu8_pkg::FUNC_OR:  value = {8'h00, a | b};
         alu8_pkg::FUNC_NOT: value = {8'h00, ~a};
         alu8_pkg::FUNC_XOR: value = {8'h00, a ^ b};
         alu8_pkg::FUNC_SHR: value = {9'h000, a[7:1]};
         alu8_pkg::FUNC_SHL: value = {7'h00, a, 1'b0};
         default:            known = 1'b0;
      endcase
      if (known) begin
         r.result        = value;
         r.carry_flag    = (value > 16'h00FF);
         r.zero_flag     = (value == 16'h0000);
         r.overflow_flag = (value > 16'h007F);
         r.sign_flag     = value[7];
         r.invalid_op    = 1'b0;
      end else begin
         r.result        = 16'h0000;
         r.carry_flag    = 1'b0;
         r.zero_flag     = 1'b0;
         r.overflow_flag = 1'b0;
         r.sign_flag     = 1'b0;
         r.invalid_op    = 1'b1;
      end
      return r;
   endfunction

   function void note_operation(logic [7:0] a, logic [7:0] b, logic [7:0] func);
      pending_results.push_back(alu_outcome(a, b, func));
   endfunction

   function int unsigned outstanding();
      return pending_results.size();
   endfunction

   function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         errors++;
      end
   endfunction

   function void check_result(alu8_pkg::rsp_type got);
      alu8_pkg::rsp_type want;
      if (pending_results.size() == 0) begin
         $error("response transaction with nothing expected");
         errors++;
         return;
      end
      want = pending_results.pop_front();
      compare_field("result", want.result, got.result);
      compare_field("carry_flag", 16'(want.carry_flag), 16'(got.carry_flag));
      compare_field("zero_flag", 16'(want.zero_flag), 16'(got.zero_flag));
      compare_field("overflow_flag", 16'(want.overflow_flag), 16'(got.overflow_flag));
      compare_field("sign_flag", 16'(want.sign_flag), 16'(got.sign_flag));
      compare_field("invalid_op", 16'(want.invalid_op), 16'(got.invalid_op));
   endfunction
endclass

module testbench;

   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 12;
   localparam logic [7:0] KNOWN_FUNCS [9] = '{alu8_pkg::FUNC_ADD, alu8_pkg::FUNC_SUB,
                                              alu8_pkg::FUNC_MUL, alu8_pkg::FUNC_AND,
                                              alu8_pkg::FUNC_OR, alu8_pkg::FUNC_NOT,
                                              alu8_pkg::FUNC_XOR, alu8_pkg::FUNC_SHR,
                                              alu8_pkg::FUNC_SHL};
   localparam logic [7:0] CORNER_BYTES [6] = '{8'h00, 8'h01, 8'h7F, 8'h80, 8'h81, 8'hFF};

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = 16'h0000;   // op_a, op_b
   logic [7:0]  req_tuser  = 8'h00;      // func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;               // result, carry, zero, overflow, sign flags
   logic [0:0]  rsp_tuser;               // invalid_op

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned quiet_cycles  = 0;

   alu8_result_tracker tracker;
   alu8_pkg::rsp_type  seen;

   alu8_booth_flags_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_tready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // transaction monitor and stall watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            tracker.note_operation(req_tdata[7:0], req_tdata[15:8], req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            seen.result        = rsp_tdata[15:0];
            seen.carry_flag    = rsp_tdata[16];
            seen.zero_flag     = rsp_tdata[17];
            seen.overflow_flag = rsp_tdata[18];
            seen.sign_flag     = rsp_tdata[19];
            seen.invalid_op    = rsp_tuser[0];
            tracker.check_result(seen);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task send_item(input logic [7:0] a, input logic [7:0] b, input logic [7:0] func);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {b, a};
      req_tuser  <= func;
      do @(posedge clock); while (!req_tready);
   endtask

   task wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (tracker.outstanding() != 0) @(negedge clock);
   endtask

   function logic [7:0] pick_byte();
      if ($urandom_range(3) == 0) return CORNER_BYTES[3'($urandom_range(5))];
      return 8'($urandom_range(255));
   endfunction

   task send_random(input int count);
      logic [7:0] func;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 80) func = KNOWN_FUNCS[4'($urandom_range(8))];
         else func = 8'($urandom_range(255));
         send_item(pick_byte(), pick_byte(), func);
      end
   endtask

   initial begin
      tracker = new();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 22;
      recv_idle_pct = 70;
      send_item(8'hFF, 8'hFF, alu8_pkg::FUNC_ADD);
      send_item(8'h00, 8'h00, alu8_pkg::FUNC_ADD);
      send_item(8'h5A, 8'h00, alu8_pkg::FUNC_SUB);    // subtract of zero
      send_item(8'h00, 8'h01, alu8_pkg::FUNC_SUB);
      send_item(8'h80, 8'h80, alu8_pkg::FUNC_SUB);
      send_item(8'h80, 8'h80, alu8_pkg::FUNC_MUL);    // multiplicand 0x80 wraps the accumulator
      send_item(8'h80, 8'h01, alu8_pkg::FUNC_MUL);
      send_item(8'h80, 8'hFF, alu8_pkg::FUNC_MUL);
      send_item(8'hFF, 8'hFF, alu8_pkg::FUNC_MUL);
      send_item(8'h7F, 8'h81, alu8_pkg::FUNC_MUL);
      send_item(8'h00, 8'hA5, alu8_pkg::FUNC_MUL);
      send_item(8'hFF, 8'h00, alu8_pkg::FUNC_AND);
      send_item(8'hFF, 8'hFF, alu8_pkg::FUNC_AND);
      send_item(8'h00, 8'h00, alu8_pkg::FUNC_OR);
      send_item(8'hFF, 8'h00, alu8_pkg::FUNC_NOT);
      send_item(8'h00, 8'hFF, alu8_pkg::FUNC_NOT);
      send_item(8'hAA, 8'h55, alu8_pkg::FUNC_XOR);
      send_item(8'h01, 8'h00, alu8_pkg::FUNC_SHR);
      send_item(8'hFF, 8'hFF, alu8_pkg::FUNC_SHR);
      send_item(8'h80, 8'h00, alu8_pkg::FUNC_SHL);
      send_item(8'hFF, 8'h00, alu8_pkg::FUNC_SHL);
      send_item(8'h12, 8'h34, 8'h00);       // unknown opcodes
      send_item(8'hFF, 8'hFF, 8'h0A);
      send_item(8'h80, 8'h7F, 8'hFF);
      send_random(560);
      wait_for_drain();

      send_idle_pct = 70;
      recv_idle_pct = 22;
      send_random(570);
      wait_for_drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(570);
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (tracker.outstanding() != 0) begin
         $error("%0d expected responses never arrived", tracker.outstanding());
         tracker.errors++;
      end
      if (tracker.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
